/* rtl/core/sgcr_pkg.sv */
package sgcr_pkg;

  localparam int GLYPH_SIZE = 8;
  localparam int MAX_DIM    = 1024;
  localparam int MAX_SCALE  = 15;

  localparam int NUM_BITS   = GLYPH_SIZE * GLYPH_SIZE;
  localparam int COL_W      = $clog2(GLYPH_SIZE);
  localparam int DIM_W      = 11;
  localparam int STRIDE_W   = 12;
  localparam int SCALE_W    = 4;
  localparam int COORD_W    = 18;
  localparam int POS_W      = 10;
  localparam int SIZE_W     = 4;
  localparam int ADDR_W     = 21;
  localparam int COLOR_W    = 16;
  localparam int IN_COORD_W = 16;
  localparam int OFF_W      = 7;
  localparam int PROD_W     = POS_W + STRIDE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [DIM_W-1:0]      DIM_CAP          = DIM_W'(MAX_DIM);
  localparam logic [SCALE_W-1:0]    SCALE_CAP        = SCALE_W'(MAX_SCALE);
  localparam logic [DIM_W-1:0]      RST_CANVAS_W     = DIM_W'(320);
  localparam logic [DIM_W-1:0]      RST_CANVAS_H     = DIM_W'(240);
  localparam logic [STRIDE_W-1:0]   RST_STRIDE       = STRIDE_W'(320);

  localparam logic [CFG_IDX_W-1:0]  REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0]  REG_ROW_STRIDE    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MASK,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic mask;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic none_visible;
    logic mask_zero;
    logic cur_set;
    logic last;
  } status_t;

endpackage

/* rtl/core/sgcr_ctrl.sv */
module sgcr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  sgcr_pkg::status_t st,
  output sgcr_pkg::cmd_t    cmd
);

  sgcr_pkg::state_t state;
  sgcr_pkg::state_t state_next;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgcr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sgcr_pkg::ST_IDLE: begin
        if (in_valid) state_next = sgcr_pkg::ST_SETUP;
      end
      sgcr_pkg::ST_SETUP: begin
        state_next = st.none_visible ? sgcr_pkg::ST_IDLE : sgcr_pkg::ST_MASK;
      end
      sgcr_pkg::ST_MASK: begin
        state_next = st.mask_zero ? sgcr_pkg::ST_IDLE : sgcr_pkg::ST_SCAN;
      end
      sgcr_pkg::ST_SCAN: begin
        if (out_free && st.cur_set && st.last) state_next = sgcr_pkg::ST_IDLE;
      end
      default: state_next = sgcr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    cmd       = '0;
    unique case (state)
      sgcr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      sgcr_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      sgcr_pkg::ST_MASK: begin
        cmd.mask = 1'b1;
      end
      sgcr_pkg::ST_SCAN: begin
        cmd.step = out_free;
        cmd.emit = out_free && st.cur_set;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.step || cmd.mask || cmd.setup) |-> !cmd.load)
    else $error("new item loaded while a glyph is in work");

endmodule

/* rtl/core/sgcr_datapath.sv */
module sgcr_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sgcr_pkg::cmd_t                        cmd,
  output sgcr_pkg::status_t                     st,
  input  logic [sgcr_pkg::DIM_W-1:0]            cw,
  input  logic [sgcr_pkg::DIM_W-1:0]            ch,
  input  logic [sgcr_pkg::STRIDE_W-1:0]         stride,
  input  logic signed [sgcr_pkg::IN_COORD_W-1:0] glyph_x,
  input  logic signed [sgcr_pkg::IN_COORD_W-1:0] glyph_y,
  input  logic [sgcr_pkg::NUM_BITS-1:0]         glyph_bits,
  input  logic [sgcr_pkg::SCALE_W-1:0]          pixel_scale,
  input  logic [sgcr_pkg::COLOR_W-1:0]          ink_color,
  output logic [sgcr_pkg::POS_W-1:0]            cell_x,
  output logic [sgcr_pkg::POS_W-1:0]            cell_y,
  output logic [sgcr_pkg::SIZE_W-1:0]           cell_width,
  output logic [sgcr_pkg::SIZE_W-1:0]           cell_height,
  output logic [sgcr_pkg::ADDR_W-1:0]           cell_address,
  output logic [sgcr_pkg::COLOR_W-1:0]          fill_color,
  output logic                                  last_cell
);

  localparam int CW = sgcr_pkg::COORD_W;

  // latched item
  logic signed [CW-1:0]                 gx0_q, gy0_q;
  logic [sgcr_pkg::NUM_BITS-1:0]        bits_q;
  logic [sgcr_pkg::SCALE_W-1:0]         scale_q;
  logic [sgcr_pkg::COLOR_W-1:0]         color_q;

  // clipped glyph box
  logic signed [CW-1:0]                 bx0_q, by0_q, bx1_q, by1_q;

  // scan state
  logic [sgcr_pkg::NUM_BITS-1:0]        eff_q;
  logic [sgcr_pkg::COL_W-1:0]           gx_q;
  logic signed [CW-1:0]                 px_q, py_q;
  logic signed [CW-1:0]                 row_cy0_q, row_cy1_q;

  logic signed [CW-1:0]                 scale_s, size_s, cw_s, ch_s;
  logic signed [CW-1:0]                 gx_end, gy_end;
  logic signed [CW-1:0]                 bx0_c, by0_c, bx1_c, by1_c;
  logic [sgcr_pkg::GLYPH_SIZE-1:0]      colv, rowv;
  logic [sgcr_pkg::NUM_BITS-1:0]        eff_c;
  logic signed [CW-1:0]                 py_first_end, py_next, py_next_end;
  logic signed [CW-1:0]                 px_end, cx0, cx1, cell_w_s, cell_h_s;
  logic [sgcr_pkg::PROD_W-1:0]          row_prod;
  logic [sgcr_pkg::ADDR_W-1:0]          addr_c;

  assign scale_s = {{(CW-sgcr_pkg::SCALE_W){1'b0}}, scale_q};
  assign size_s  = {{(CW-sgcr_pkg::SCALE_W-sgcr_pkg::COL_W){1'b0}}, scale_q,
                    {sgcr_pkg::COL_W{1'b0}}};
  assign cw_s    = {{(CW-sgcr_pkg::DIM_W){1'b0}}, cw};
  assign ch_s    = {{(CW-sgcr_pkg::DIM_W){1'b0}}, ch};

  // box clip
  always_comb begin
    gx_end = gx0_q + size_s;
    gy_end = gy0_q + size_s;
    bx0_c  = (gx0_q < 0) ? '0 : gx0_q;
    by0_c  = (gy0_q < 0) ? '0 : gy0_q;
    bx1_c  = (gx_end < cw_s) ? gx_end : cw_s;
    by1_c  = (gy_end < ch_s) ? gy_end : ch_s;
    st.none_visible = (scale_q == '0) || ({1'b0, cw} > stride) ||
                      (bx0_c >= bx1_c) || (by0_c >= by1_c);
  end

  // per row and per column visibility, then the mask of cells to emit
  always_comb begin
    logic [sgcr_pkg::OFF_W-1:0] off;
    logic signed [CW-1:0]       p;
    for (int i = 0; i < sgcr_pkg::GLYPH_SIZE; i++) begin
      off     = sgcr_pkg::OFF_W'(i) * {{(sgcr_pkg::OFF_W-sgcr_pkg::SCALE_W){1'b0}}, scale_q};
      p       = gx0_q + {{(CW-sgcr_pkg::OFF_W){1'b0}}, off};
      colv[i] = !((p >= bx1_q) || (p + scale_s <= bx0_q));
      p       = gy0_q + {{(CW-sgcr_pkg::OFF_W){1'b0}}, off};
      rowv[i] = !((p >= by1_q) || (p + scale_s <= by0_q));
    end
    for (int r = 0; r < sgcr_pkg::GLYPH_SIZE; r++) begin
      for (int c = 0; c < sgcr_pkg::GLYPH_SIZE; c++) begin
        eff_c[r*sgcr_pkg::GLYPH_SIZE+c] = bits_q[r*sgcr_pkg::GLYPH_SIZE+c] & rowv[r] & colv[c];
      end
    end
    st.mask_zero = (eff_c == '0);
  end

  assign py_first_end = gy0_q + scale_s;
  assign py_next      = py_q + scale_s;
  assign py_next_end  = py_next + scale_s;

  // current cell
  always_comb begin
    px_end   = px_q + scale_s;
    cx0      = (px_q < bx0_q) ? bx0_q : px_q;
    cx1      = (px_end < bx1_q) ? px_end : bx1_q;
    cell_w_s = cx1 - cx0;
    cell_h_s = row_cy1_q - row_cy0_q;
    row_prod = {{sgcr_pkg::STRIDE_W{1'b0}}, row_cy0_q[sgcr_pkg::POS_W-1:0]}
             * {{sgcr_pkg::POS_W{1'b0}}, stride};
    addr_c   = row_prod[sgcr_pkg::ADDR_W-1:0]
             + {{(sgcr_pkg::ADDR_W-sgcr_pkg::POS_W){1'b0}}, cx0[sgcr_pkg::POS_W-1:0]};
  end

  assign st.cur_set = eff_q[0];
  assign st.last    = (eff_q[sgcr_pkg::NUM_BITS-1:1] == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gx0_q   <= {{(CW-sgcr_pkg::IN_COORD_W){glyph_x[sgcr_pkg::IN_COORD_W-1]}}, glyph_x};
      gy0_q   <= {{(CW-sgcr_pkg::IN_COORD_W){glyph_y[sgcr_pkg::IN_COORD_W-1]}}, glyph_y};
      bits_q  <= glyph_bits;
      scale_q <= (pixel_scale > sgcr_pkg::SCALE_CAP) ? sgcr_pkg::SCALE_CAP : pixel_scale;
      color_q <= ink_color;
    end
    if (cmd.setup) begin
      bx0_q <= bx0_c;
      by0_q <= by0_c;
      bx1_q <= bx1_c;
      by1_q <= by1_c;
    end
    if (cmd.mask) begin
      eff_q     <= eff_c;
      gx_q      <= '0;
      px_q      <= gx0_q;
      py_q      <= gy0_q;
      row_cy0_q <= (gy0_q < by0_q) ? by0_q : gy0_q;
      row_cy1_q <= (py_first_end < by1_q) ? py_first_end : by1_q;
    end else if (cmd.step) begin
      eff_q <= eff_q >> 1;
      gx_q  <= gx_q + 1'b1;
      // row wrap
      if (gx_q == sgcr_pkg::COL_W'(sgcr_pkg::GLYPH_SIZE - 1)) begin
        px_q      <= gx0_q;
        py_q      <= py_next;
        row_cy0_q <= (py_next < by0_q) ? by0_q : py_next;
        row_cy1_q <= (py_next_end < by1_q) ? py_next_end : by1_q;
      end else begin
        px_q <= px_end;
      end
    end
    if (cmd.emit) begin
      cell_x       <= cx0[sgcr_pkg::POS_W-1:0];
      cell_y       <= row_cy0_q[sgcr_pkg::POS_W-1:0];
      cell_width   <= cell_w_s[sgcr_pkg::SIZE_W-1:0];
      cell_height  <= cell_h_s[sgcr_pkg::SIZE_W-1:0];
      cell_address <= addr_c;
      fill_color   <= color_q;
      last_cell    <= st.last;
    end
  end

  a_step_has_work: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (eff_q != '0))
    else $error("scan step with no cell left");

  a_cell_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (cell_width != '0) && (cell_height != '0))
    else $error("emitted cell is empty");

  a_cell_fits_scale: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (cell_width <= scale_q) && (cell_height <= scale_q))
    else $error("emitted cell larger than one glyph pixel");

endmodule

/* rtl/core/scaled_glyph_cell_rasterizer_unit.sv */
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------------------
// in       | in_valid / in_stall        | glyph_x, glyph_y, glyph_bits, pixel_scale,
//          |                            | ink_color
// out      | out_valid / out_stall      | cell_x, cell_y, cell_width, cell_height,
//          |                            | cell_address, fill_color, last_cell
// cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// an item is taken in idle, then a setup state (box clip) and a mask state
// (row/column visibility), then a scan state steps through the glyph bits up to the
// last visible set bit; in_stall stays high until the glyph is done.
// out_stall holds the scan; the result register lets the next item be taken
// while the final cell of the previous glyph still waits.
// synchronous reset restores the canvas registers to 320 x 240, stride 320.
module scaled_glyph_cell_rasterizer_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [sgcr_pkg::IN_COORD_W-1:0] glyph_x,
  input  logic signed [sgcr_pkg::IN_COORD_W-1:0] glyph_y,
  input  logic [sgcr_pkg::NUM_BITS-1:0]          glyph_bits,
  input  logic [sgcr_pkg::SCALE_W-1:0]           pixel_scale,
  input  logic [sgcr_pkg::COLOR_W-1:0]           ink_color,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [sgcr_pkg::POS_W-1:0]             cell_x,
  output logic [sgcr_pkg::POS_W-1:0]             cell_y,
  output logic [sgcr_pkg::SIZE_W-1:0]            cell_width,
  output logic [sgcr_pkg::SIZE_W-1:0]            cell_height,
  output logic [sgcr_pkg::ADDR_W-1:0]            cell_address,
  output logic [sgcr_pkg::COLOR_W-1:0]           fill_color,
  output logic                                   last_cell,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sgcr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sgcr_pkg::CFG_DATA_W-1:0]        cfg_data
);

  logic [sgcr_pkg::DIM_W-1:0]    canvas_width;
  logic [sgcr_pkg::DIM_W-1:0]    canvas_height;
  logic [sgcr_pkg::STRIDE_W-1:0] row_stride;
  logic [sgcr_pkg::DIM_W-1:0]    cw_eff, ch_eff;
  sgcr_pkg::cmd_t                cmd;
  sgcr_pkg::status_t             st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= sgcr_pkg::RST_CANVAS_W;
      canvas_height <= sgcr_pkg::RST_CANVAS_H;
      row_stride    <= sgcr_pkg::RST_STRIDE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sgcr_pkg::REG_CANVAS_WIDTH:  canvas_width  <= cfg_data[sgcr_pkg::DIM_W-1:0];
        sgcr_pkg::REG_CANVAS_HEIGHT: canvas_height <= cfg_data[sgcr_pkg::DIM_W-1:0];
        sgcr_pkg::REG_ROW_STRIDE:    row_stride    <= cfg_data;
        default: ;
      endcase
    end
  end

  // canvas sizes above the supported maximum are clamped
  assign cw_eff = (canvas_width  > sgcr_pkg::DIM_CAP) ? sgcr_pkg::DIM_CAP : canvas_width;
  assign ch_eff = (canvas_height > sgcr_pkg::DIM_CAP) ? sgcr_pkg::DIM_CAP : canvas_height;

  sgcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  sgcr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cw           (cw_eff),
    .ch           (ch_eff),
    .stride       (row_stride),
    .glyph_x      (glyph_x),
    .glyph_y      (glyph_y),
    .glyph_bits   (glyph_bits),
    .pixel_scale  (pixel_scale),
    .ink_color    (ink_color),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .cell_width   (cell_width),
    .cell_height  (cell_height),
    .cell_address (cell_address),
    .fill_color   (fill_color),
    .last_cell    (last_cell)
  );

endmodule
